### rtl/core/hbrps_pkg.sv
package hbrps_pkg;

	localparam int unsigned TimeW    = 32;
	localparam int unsigned PctW     = 7;
	localparam int unsigned DutyW    = 8;
	localparam int unsigned IvW      = 10;
	localparam int unsigned HoldW    = 16;
	localparam int unsigned GapW     = 10;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned DivSteps = TimeW;
	localparam int unsigned DivCntW  = $clog2(DivSteps);

	localparam logic [2:0] OP_UPDATE      = 3'd0;
	localparam logic [2:0] OP_SET_TARGET  = 3'd1;
	localparam logic [2:0] OP_STOP        = 3'd2;
	localparam logic [2:0] OP_START_TEST  = 3'd3;
	localparam logic [2:0] OP_RUN_PATTERN = 3'd4;
	localparam logic [2:0] OP_CONSUME     = 3'd5;

	localparam logic [1:0] DIR_STOP    = 2'd0;
	localparam logic [1:0] DIR_FWD     = 2'd1;
	localparam logic [1:0] DIR_REV     = 2'd2;
	localparam logic [1:0] DIR_INVALID = 2'd3;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_UP   = 3'd1;
	localparam logic [2:0] PH_HOLD = 3'd2;
	localparam logic [2:0] PH_DOWN = 3'd3;
	localparam logic [2:0] PH_GAP  = 3'd4;

	localparam logic [CfgIdxW-1:0] CFG_ENABLED     = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_MAX_PERCENT = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_TEST_PCT    = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_TEST_HOLD   = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_RAMP_IV     = 3'd4;

	localparam logic [PctW-1:0]  RST_MAX_PERCENT = 7'd100;
	localparam logic [PctW-1:0]  RST_TEST_PCT    = 7'd50;
	localparam logic [HoldW-1:0] RST_TEST_HOLD   = 16'd1000;
	localparam logic [IvW-1:0]   RST_RAMP_IV     = 10'd20;

	localparam logic [PctW-1:0]  PCT_FULL   = 7'd100;
	localparam logic [2:0]       STEP_CAP   = 3'd5;
	localparam logic [7:0]       PULSE_CAP  = 8'd3;
	localparam logic [GapW-1:0]  GAP_CAP    = 10'd1000;
	localparam logic [HoldW-1:0] HOLD_CAP   = 16'd4000;
	localparam logic [27:0]      DUTY_RECIP = 28'd5243;
	localparam int unsigned      DutyShift  = 19;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [TimeW-1:0] now_ms;
		logic [7:0]       percent;
		logic [1:0]       direction;
		logic [TimeW-1:0] hold_ms;
		logic [7:0]       pulse_count;
		logic [TimeW-1:0] gap_ms;
	} cmd_t;

	typedef struct packed {
		logic [DutyW-1:0] duty_a;
		logic [DutyW-1:0] duty_b;
		logic             bridge_awake;
		logic [PctW-1:0]  speed_now;
		logic [2:0]       phase_now;
		logic             test_done;
	} res_t;

	typedef struct packed {
		logic latch;
		logic step;
		logic exec;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic divide;
		logic div_last;
	} ctl_sts_t;

	// Duty is percent * 255 / 100 with percent clamped at 100; the division uses
	// a reciprocal that is exact over this range.
	function automatic logic [DutyW-1:0] duty_of(logic [PctW-1:0] p);
		logic [PctW-1:0] pc;
		logic [14:0]     prod;
		logic [27:0]     scaled;
		pc     = (p > PCT_FULL) ? PCT_FULL : p;
		prod   = {pc, 8'd0} - {8'd0, pc};
		scaled = {13'd0, prod} * DUTY_RECIP;
		return scaled[DutyShift +: DutyW];
	endfunction

endpackage

### rtl/core/hbrps_cmd_if.sv
interface hbrps_cmd_if;
	import hbrps_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/core/hbrps_res_if.sv
interface hbrps_res_if;
	import hbrps_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/core/hbrps_ctrl.sv
module hbrps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  hbrps_pkg::ctl_sts_t sts,
	output hbrps_pkg::ctl_cmd_t ctl
);
	import hbrps_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EXEC,
		ST_PRESENT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		ctl.latch    = in_valid && in_ready;
		ctl.step     = (state_q == ST_DIVIDE);
		ctl.exec     = (state_q == ST_EXEC);
		ctl.load_out = (state_q == ST_PRESENT) && (!out_valid_q || out_ready);
		out_valid    = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.latch) begin
						state_q <= sts.divide ? ST_DIVIDE : ST_EXEC;
					end
				end
				ST_DIVIDE: begin
					if (sts.div_last) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_PRESENT;
				end
				ST_PRESENT: begin
					if (ctl.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

### rtl/core/hbrps_datapath.sv
module hbrps_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [hbrps_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [hbrps_pkg::CfgDataW-1:0]   cfg_wdata,
	input  hbrps_pkg::cmd_t                  in_data,
	input  hbrps_pkg::ctl_cmd_t              ctl,
	output hbrps_pkg::ctl_sts_t              sts,
	output hbrps_pkg::res_t                  res_data
);
	import hbrps_pkg::*;

	function automatic logic [2*DutyW-1:0] side_duty(logic [1:0] dir, logic [PctW-1:0] p);
		logic [DutyW-1:0] d;
		d = duty_of(p);
		if (dir == DIR_FWD) begin
			return {d, {DutyW{1'b0}}};
		end else if (dir == DIR_REV) begin
			return {{DutyW{1'b0}}, d};
		end
		return '0;
	endfunction

	logic              enabled_q;
	logic [PctW-1:0]   max_pct_q;
	logic [PctW-1:0]   test_pct_q;
	logic [HoldW-1:0]  test_hold_q;
	logic [IvW-1:0]    ramp_iv_q;

	cmd_t              cmd_q;
	logic [TimeW-1:0]  el_q;
	logic [TimeW-1:0]  quo_q;
	logic [IvW-1:0]    rem_q;
	logic [DivCntW-1:0] cnt_q;

	logic [1:0]        dir_q;
	logic [PctW-1:0]   cur_q;
	logic [PctW-1:0]   tgt_q;
	logic [TimeW-1:0]  last_q;
	logic [2:0]        ph_q;
	logic [1:0]        left_q;
	logic [PctW-1:0]   pat_q;
	logic [GapW-1:0]   gap_q;
	logic [HoldW-1:0]  hold_q;
	logic [TimeW-1:0]  hst_q;
	logic [TimeW-1:0]  gst_q;
	logic              rep_q;
	logic              cmp_q;
	logic [DutyW-1:0]  da_q;
	logic [DutyW-1:0]  db_q;
	logic              awk_q;
	logic              done_q;
	res_t              res_q;

	logic [IvW-1:0]    iv;
	logic [IvW:0]      trial;
	logic              trial_ge;

	logic [1:0]        dir_n;
	logic [PctW-1:0]   cur_n;
	logic [PctW-1:0]   tgt_n;
	logic [TimeW-1:0]  last_n;
	logic [2:0]        ph_n;
	logic [1:0]        left_n;
	logic [PctW-1:0]   pat_n;
	logic [GapW-1:0]   gap_n;
	logic [HoldW-1:0]  hold_n;
	logic [TimeW-1:0]  hst_n;
	logic [TimeW-1:0]  gst_n;
	logic              rep_n;
	logic              cmp_n;
	logic [DutyW-1:0]  da_n;
	logic [DutyW-1:0]  db_n;
	logic              awk_n;
	logic              done_n;

	logic [PctW-1:0]   pct_c;
	logic [1:0]        dir_in;
	logic [2:0]        nsat;
	logic [PctW-1:0]   step;
	logic [PctW-1:0]   diff;
	logic [7:0]        cnt_c;

	always_comb begin
		iv       = (ramp_iv_q == '0) ? IvW'(1) : ramp_iv_q;
		trial    = {rem_q, quo_q[TimeW-1]};
		trial_ge = (trial >= {1'b0, iv});
		sts.divide   = enabled_q && (in_data.opcode == OP_UPDATE);
		sts.div_last = (cnt_q == DivCntW'(DivSteps - 1));
		res_data     = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= 1'b1;
			max_pct_q   <= RST_MAX_PERCENT;
			test_pct_q  <= RST_TEST_PCT;
			test_hold_q <= RST_TEST_HOLD;
			ramp_iv_q   <= RST_RAMP_IV;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ENABLED:     enabled_q   <= cfg_wdata[0];
				CFG_MAX_PERCENT: max_pct_q   <= cfg_wdata[PctW-1:0];
				CFG_TEST_PCT:    test_pct_q  <= cfg_wdata[PctW-1:0];
				CFG_TEST_HOLD:   test_hold_q <= cfg_wdata[HoldW-1:0];
				CFG_RAMP_IV:     ramp_iv_q   <= cfg_wdata[IvW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Restoring divider: elapsed time over the ramp interval, one quotient bit a cycle.
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= in_data;
			el_q  <= in_data.now_ms - last_q;
			quo_q <= in_data.now_ms - last_q;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (ctl.step) begin
			rem_q <= trial_ge ? IvW'(trial - {1'b0, iv}) : trial[IvW-1:0];
			quo_q <= {quo_q[TimeW-2:0], trial_ge};
			cnt_q <= cnt_q + DivCntW'(1);
		end
		if (ctl.load_out) begin
			res_q.duty_a       <= enabled_q ? da_q : '0;
			res_q.duty_b       <= enabled_q ? db_q : '0;
			res_q.bridge_awake <= enabled_q && awk_q;
			res_q.speed_now    <= cur_q;
			res_q.phase_now    <= ph_q;
			res_q.test_done    <= done_q;
		end
	end

	always_comb begin
		dir_n  = dir_q;
		cur_n  = cur_q;
		tgt_n  = tgt_q;
		last_n = last_q;
		ph_n   = ph_q;
		left_n = left_q;
		pat_n  = pat_q;
		gap_n  = gap_q;
		hold_n = hold_q;
		hst_n  = hst_q;
		gst_n  = gst_q;
		rep_n  = rep_q;
		cmp_n  = cmp_q;
		da_n   = da_q;
		db_n   = db_q;
		awk_n  = awk_q;
		done_n = cmp_q;

		pct_c  = (cmd_q.percent > {1'b0, max_pct_q}) ? max_pct_q : cmd_q.percent[PctW-1:0];
		dir_in = (cmd_q.direction == DIR_INVALID) ? DIR_STOP : cmd_q.direction;
		nsat   = ((quo_q[TimeW-1:3] != '0) || (quo_q[2:0] >= STEP_CAP)) ? STEP_CAP : quo_q[2:0];
		step   = {3'd0, nsat, 1'b0};
		diff   = '0;
		cnt_c  = (cmd_q.pulse_count > PULSE_CAP) ? PULSE_CAP : cmd_q.pulse_count;

		if (cmd_q.opcode == OP_CONSUME) begin
			cmp_n = 1'b0;
		end else if (enabled_q) begin
			if (cmd_q.opcode inside {OP_STOP, OP_START_TEST, OP_RUN_PATTERN}) begin
				tgt_n  = '0;
				cur_n  = '0;
				dir_n  = DIR_STOP;
				da_n   = '0;
				db_n   = '0;
				awk_n  = 1'b0;
				ph_n   = PH_IDLE;
				rep_n  = 1'b0;
				left_n = '0;
			end
			case (cmd_q.opcode)
				OP_UPDATE: begin
					if (quo_q != '0) begin
						last_n = last_q + (el_q - TimeW'(rem_q));
						if (cur_n < tgt_n) begin
							diff  = tgt_n - cur_n;
							cur_n = cur_n + ((step < diff) ? step : diff);
							{da_n, db_n} = side_duty(dir_n, cur_n);
						end else if (cur_n > tgt_n) begin
							diff  = cur_n - tgt_n;
							cur_n = cur_n - ((step < diff) ? step : diff);
							{da_n, db_n} = side_duty(dir_n, cur_n);
							if (cur_n == '0) begin
								dir_n = DIR_STOP;
								da_n  = '0;
								db_n  = '0;
								awk_n = 1'b0;
							end
						end
					end
					case (ph_q)
						PH_UP: begin
							if (cur_n >= tgt_n) begin
								hst_n = cmd_q.now_ms;
								ph_n  = PH_HOLD;
							end
						end
						PH_HOLD: begin
							if ((cmd_q.now_ms - hst_q) >= TimeW'(hold_q)) begin
								tgt_n = '0;
								ph_n  = PH_DOWN;
							end
						end
						PH_DOWN: begin
							if (cur_n == '0) begin
								dir_n = DIR_STOP;
								da_n  = '0;
								db_n  = '0;
								awk_n = 1'b0;
								if (left_q != '0) begin
									left_n = left_q - 2'd1;
									gst_n  = cmd_q.now_ms;
									ph_n   = PH_GAP;
								end else begin
									ph_n  = PH_IDLE;
									rep_n = 1'b0;
									if (rep_q) begin
										cmp_n = 1'b1;
									end
								end
							end
						end
						PH_GAP: begin
							if ((cmd_q.now_ms - gst_q) >= TimeW'(gap_q)) begin
								dir_n = DIR_FWD;
								awk_n = 1'b1;
								tgt_n = pat_q;
								ph_n  = PH_UP;
							end
						end
						default: begin
						end
					endcase
				end
				OP_SET_TARGET: begin
					if ((cur_n != '0) && (dir_in != dir_n)) begin
						tgt_n = '0;
					end else begin
						if (cur_n == '0) begin
							dir_n = dir_in;
							if (dir_in == DIR_STOP) begin
								da_n  = '0;
								db_n  = '0;
								awk_n = 1'b0;
							end else begin
								awk_n = 1'b1;
							end
						end
						tgt_n  = pct_c;
						ph_n   = PH_IDLE;
						left_n = '0;
					end
				end
				OP_START_TEST: begin
					dir_n  = DIR_FWD;
					awk_n  = 1'b1;
					tgt_n  = test_pct_q;
					hold_n = test_hold_q;
					ph_n   = PH_UP;
					rep_n  = 1'b1;
					cmp_n  = 1'b0;
					last_n = cmd_q.now_ms;
				end
				OP_RUN_PATTERN: begin
					if ((pct_c != '0) && (cmd_q.hold_ms != '0) && (cmd_q.pulse_count != '0)) begin
						dir_n  = DIR_FWD;
						awk_n  = 1'b1;
						tgt_n  = pct_c;
						pat_n  = pct_c;
						left_n = cnt_c[1:0] - 2'd1;
						gap_n  = (cmd_q.gap_ms > TimeW'(GAP_CAP)) ? GAP_CAP
							: cmd_q.gap_ms[GapW-1:0];
						hold_n = (cmd_q.hold_ms > TimeW'(HOLD_CAP)) ? HOLD_CAP
							: cmd_q.hold_ms[HoldW-1:0];
						ph_n   = PH_UP;
						rep_n  = 1'b0;
						cmp_n  = 1'b0;
						last_n = cmd_q.now_ms;
					end
				end
				default: begin
				end
			endcase
			done_n = cmp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_STOP;
			cur_q  <= '0;
			tgt_q  <= '0;
			last_q <= '0;
			ph_q   <= PH_IDLE;
			left_q <= '0;
			pat_q  <= '0;
			gap_q  <= '0;
			hold_q <= '0;
			hst_q  <= '0;
			gst_q  <= '0;
			rep_q  <= 1'b0;
			cmp_q  <= 1'b0;
			da_q   <= '0;
			db_q   <= '0;
			awk_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.exec) begin
			dir_q  <= dir_n;
			cur_q  <= cur_n;
			tgt_q  <= tgt_n;
			last_q <= last_n;
			ph_q   <= ph_n;
			left_q <= left_n;
			pat_q  <= pat_n;
			gap_q  <= gap_n;
			hold_q <= hold_n;
			hst_q  <= hst_n;
			gst_q  <= gst_n;
			rep_q  <= rep_n;
			cmp_q  <= cmp_n;
			da_q   <= da_n;
			db_q   <= db_n;
			awk_q  <= awk_n;
			done_q <= done_n;
		end
	end
endmodule

### rtl/core/hbridge_ramp_pulse_sequencer.sv
// H-bridge ramp and pulse sequencer.
// Commands enter on the cmd channel and one status result per command leaves on
// the res channel; both use valid/ready and a transfer happens when both are high.
// Registers are written through cfg_wr_en, cfg_index and cfg_wdata while the block
// is idle: the user must keep to that, as the block does not enforce it. A write
// takes effect at the next clock edge. An update command with the block enabled
// runs a 32-step serial divide of the elapsed time by the ramp interval before its
// result is computed; other commands skip the divide and go straight to the execute
// state and then to the output register.
// The block takes one command at a time; cmd.ready is high only while no command
// is in progress. A finished result sits in the output register, and the next
// command may be taken while it waits. If the receiver stalls, the following
// result is held inside until the output register is free.
// Reset puts the bridge to sleep with both duties at zero, speed zero, phase
// idle, and the registers at their defaults.
module hbridge_ramp_pulse_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [hbrps_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [hbrps_pkg::CfgDataW-1:0] cfg_wdata,
	hbrps_cmd_if.sink                      cmd,
	hbrps_res_if.source                    res
);
	import hbrps_pkg::*;

	ctl_cmd_t ctl;
	ctl_sts_t sts;

	hbrps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	hbrps_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (cmd.data),
		.ctl       (ctl),
		.sts       (sts),
		.res_data  (res.data)
	);

	a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> !cmd.ready)
		else $error("command taken during divide");

	a_update_starts_divide: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && sts.divide) |=> ctl.step)
		else $error("enabled update did not start the divider");

	a_load_gives_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> res.valid)
		else $error("loaded result not presented");

	a_single_control_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.latch, ctl.step, ctl.exec, ctl.load_out}))
		else $error("overlapping control actions");
endmodule
